@@ hw/rtl/nnt_pkg.sv @@
package nnt_pkg;

  localparam int unsigned DefMaxPoints = 32;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned DistW        = 2 * CoordW + 1;   // dx^2 + dy^2
  localparam int unsigned IdxW         = 6;                // holds any index up to 63
  localparam int unsigned CityW        = 5;
  localparam int unsigned CostW        = 30;
  localparam int unsigned RootW        = CoordW + 9;       // sqrt(d2 << 16)

  // best candidate handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [DistW-1:0]  d2;
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } cand_t;

endpackage

@@ hw/rtl/nnt_cell.sv @@
module nnt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [nnt_pkg::CoordW-1:0] wr_x_i,
  input  logic [nnt_pkg::CoordW-1:0] wr_y_i,
  input  logic                      clr_visit_i,
  input  logic                      mark_i,
  input  logic                      in_set_i,
  input  logic [nnt_pkg::IdxW-1:0]  idx_i,
  input  logic [nnt_pkg::CoordW-1:0] cur_x_i,
  input  logic [nnt_pkg::CoordW-1:0] cur_y_i,
  input  nnt_pkg::cand_t            prev_i,
  output nnt_pkg::cand_t            cand_o,
  output logic [nnt_pkg::DistW-1:0] d2_o
);
  import nnt_pkg::*;

  logic [CoordW-1:0] x_q, y_q, dx, dy;
  logic [2*CoordW-1:0] sqx, sqy;
  logic [DistW-1:0] d2_q;
  logic visited_q, take;
  cand_t cand_q, cand_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
  end

  // a mark wins over a clear, so the start city stays visited at tour start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= 1'b0;
    end else if (mark_i) begin
      visited_q <= 1'b1;
    end else if (clr_visit_i) begin
      visited_q <= 1'b0;
    end
  end

  assign dx  = (x_q > cur_x_i) ? x_q - cur_x_i : cur_x_i - x_q;
  assign dy  = (y_q > cur_y_i) ? y_q - cur_y_i : cur_y_i - y_q;
  assign sqx = dx * dx;
  assign sqy = dy * dy;

  always_ff @(posedge clk_i) begin
    d2_q <= {1'b0, sqx} + {1'b0, sqy};
  end

  // strictly smaller wins, so the lower index keeps a tie
  assign take = in_set_i && !visited_q && (d2_q != '0) &&
                (!prev_i.found || (d2_q < prev_i.d2));

  always_comb begin
    cand_d = prev_i;
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.d2    = d2_q;
      cand_d.idx   = idx_i;
      cand_d.x     = x_q;
      cand_d.y     = y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;
  assign d2_o   = d2_q;

endmodule

@@ hw/rtl/nnt_sqrt.sv @@
module nnt_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [nnt_pkg::DistW-1:0] d2_i,
  output logic                      done_o,
  output logic [nnt_pkg::RootW-1:0] root_o
);
  import nnt_pkg::*;

  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned RemW = RootW + 3;
  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [RadW-1:0] rad_q;
  logic [RemW-1:0] rem_q, rem_sh, trial;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0] cnt_q;
  logic busy_q, done_q;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one root bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= RadW'({d2_i, 16'b0});
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hw/rtl/nearest_neighbor_tour_unit.sv @@
// Nearest-neighbor tour unit.
// Input stream: one point per item, tdata = {y, x}; tlast marks the final
// point and starts a greedy tour from city 0 over the stored points.
// Points load one per cycle while idle; beyond MAX_POINTS they are dropped.
// Output stream: one item per tour city, tdata = {total_cost, city},
// tlast set on the closing return to city 0.
// Each tour step sweeps the cell row: the current city's coordinates go
// to every cell, each cell squares its distance, and the best candidate
// ripples down the row one cell per cycle.
// The edge length then comes from the serial square root, and the emit
// state hands the item to the output register.
// No input is taken while a tour runs; s_axis_tready returns when the
// closing item is loaded.
// A stalled receiver holds the output register and the tour waits on it.
// Reset empties the point set and the output register.
module nearest_neighbor_tour_unit #(
  parameter int unsigned MAX_POINTS = nnt_pkg::DefMaxPoints
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_coord, [31:16] y_coord
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] city, [34:5] total_cost, zeros above
  output logic        m_axis_tlast    // tour_end
);
  import nnt_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned ScanW = $clog2(MAX_POINTS + 4);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [ScanW-1:0] scan_q, scan_d;
  logic [CoordW-1:0] x0_q, x0_d, y0_q, y0_d, cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [IdxW-1:0] city_q, city_d;
  logic closing_q, closing_d;
  logic [CostW-1:0] cost_q, cost_d;
  logic out_v_q, out_v_d, out_end_q, out_end_d;
  logic [CityW-1:0] out_city_q, out_city_d;
  logic [CostW-1:0] out_cost_q, out_cost_d;
  logic in_acc, out_free, clr_visit, mark_en, root_start, root_done;
  logic [DistW-1:0] root_arg_q, root_arg_d;
  logic [RootW-1:0] root;
  logic [CostW:0] cost_sum;

  cand_t chain [MAX_POINTS+1];
  logic [DistW-1:0] d2 [MAX_POINTS];

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    nnt_cell u_cell (
      .clk_i,
      .rst_ni,
      .wr_en_i    (in_acc && (count_q == CntW'(i))),
      .wr_x_i     (s_axis_tdata[15:0]),
      .wr_y_i     (s_axis_tdata[31:16]),
      .clr_visit_i(clr_visit),
      .mark_i     ((mark_en && (chain[MAX_POINTS].idx == IdxW'(i))) ||
                   (clr_visit && (i == 0))),
      .in_set_i   (CntW'(i) < count_q),
      .idx_i      (IdxW'(i)),
      .cur_x_i    (cur_x_q),
      .cur_y_i    (cur_y_q),
      .prev_i     (chain[i]),
      .cand_o     (chain[i+1]),
      .d2_o       (d2[i])
    );
  end

  // the root starts in the same cycle its argument is picked
  nnt_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .start_i(root_start),
    .d2_i   (root_arg_d),
    .done_o (root_done),
    .root_o (root)
  );

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  assign cost_sum      = {1'b0, cost_q} + (CostW+1)'(root);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    x0_d       = x0_q;
    y0_d       = y0_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    city_d     = city_q;
    closing_d  = closing_q;
    cost_d     = cost_q;
    root_arg_d = root_arg_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_city_d = out_city_q;
    out_cost_d = out_cost_q;
    out_end_d  = out_end_q;
    clr_visit  = 1'b0;
    mark_en    = 1'b0;
    root_start = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q < CntW'(MAX_POINTS)) begin
            count_d = count_q + 1'b1;
            if (count_q == '0) begin
              x0_d = s_axis_tdata[15:0];
              y0_d = s_axis_tdata[31:16];
            end
          end
          if (s_axis_tlast) begin
            clr_visit = 1'b1;
            cost_d    = '0;
            city_d    = '0;
            closing_d = 1'b0;
            cur_x_d   = (count_q == '0) ? s_axis_tdata[15:0] : x0_q;
            cur_y_d   = (count_q == '0) ? s_axis_tdata[31:16] : y0_q;
            state_d   = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == ScanW'(MAX_POINTS + 2)) begin
          if (chain[MAX_POINTS].found) begin
            mark_en    = 1'b1;
            root_arg_d = chain[MAX_POINTS].d2;
            city_d     = chain[MAX_POINTS].idx;
            cur_x_d    = chain[MAX_POINTS].x;
            cur_y_d    = chain[MAX_POINTS].y;
          end else begin
            // no candidate left: close back to city 0
            root_arg_d = d2[0];
            city_d     = '0;
            closing_d  = 1'b1;
          end
          root_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          cost_d  = cost_sum[CostW] ? {CostW{1'b1}} : cost_sum[CostW-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_city_d = city_q[CityW-1:0];
          out_cost_d = cost_q;
          out_end_d  = closing_q;
          scan_d     = '0;
          if (closing_q) begin
            count_d = '0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      scan_q    <= '0;
      city_q    <= '0;
      closing_q <= 1'b0;
      cost_q    <= '0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      city_q    <= city_d;
      closing_q <= closing_d;
      cost_q    <= cost_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q       <= x0_d;
    y0_q       <= y0_d;
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    root_arg_q <= root_arg_d;
    out_city_q <= out_city_d;
    out_cost_q <= out_cost_d;
    out_end_q  <= out_end_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_cost_q, out_city_q};
  assign m_axis_tlast  = out_end_q;

endmodule

@@ hw/rtl/nnt_checker.sv @@
module nnt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // a closing item always names city 0
  a_close_city: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == 5'd0)
    else $error("tour does not close at city 0");

  // input stops when the tour starts
  a_tour_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after tour start");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind nearest_neighbor_tour_unit nnt_checker u_nnt_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid,
  .s_axis_tready,
  .s_axis_tlast,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata,
  .m_axis_tlast
);

@@ verif/nearest_neighbor_tour_unit_test.sv @@
module nearest_neighbor_tour_unit_test;

  localparam int unsigned NumPoints = nnt_pkg::DefMaxPoints;
  localparam int unsigned CityW     = nnt_pkg::CityW;
  localparam int unsigned CostW     = nnt_pkg::CostW;
  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  typedef struct packed {
    logic [CityW-1:0] city;
    logic [CostW-1:0] cost;
    logic             tour_end;
  } stop_t;

  class tour_board;
    logic [15:0] xs[NumPoints];
    logic [15:0] ys[NumPoints];
    int unsigned n_pts;
    stop_t       stops_q[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_tours;

    function void clear();
      n_pts = 0;
    endfunction

    function longint unsigned dist2(int unsigned a, int unsigned b);
      longint unsigned dx, dy;
      dx = (xs[a] > xs[b]) ? xs[a] - xs[b] : xs[b] - xs[a];
      dy = (ys[a] > ys[b]) ? ys[a] - ys[b] : ys[b] - ys[a];
      return dx * dx + dy * dy;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void add_leg(ref longint unsigned acc, input int unsigned a, input int unsigned b);
      acc += root(dist2(a, b) << 16);
      if (acc > CostMax) acc = CostMax;
    endfunction

    function void note_point(logic [15:0] x, logic [15:0] y, logic last);
      bit              seen[NumPoints];
      longint unsigned acc, bd, d;
      int unsigned     cur, best;
      bit              found;
      if (n_pts < NumPoints) begin
        xs[n_pts] = x;
        ys[n_pts] = y;
        n_pts++;
      end
      if (!last) return;
      n_tours++;
      foreach (seen[i]) seen[i] = 0;
      acc = 0;
      cur = 0;
      seen[0] = 1;
      stops_q.push_back('{city: 0, cost: 0, tour_end: 0});
      forever begin
        found = 0;
        best = 0;
        bd = 0;
        for (int unsigned i = 0; i < n_pts; i++) begin
          if (seen[i]) continue;
          d = dist2(cur, i);
          if (d == 0) continue;
          if (!found || d < bd) begin
            found = 1;
            best = i;
            bd = d;
          end
        end
        if (!found) break;
        add_leg(acc, cur, best);
        seen[best] = 1;
        cur = best;
        stops_q.push_back('{city: best[CityW-1:0], cost: acc[CostW-1:0], tour_end: 0});
      end
      add_leg(acc, cur, 0);
      stops_q.push_back('{city: 0, cost: acc[CostW-1:0], tour_end: 1});
      n_pts = 0;
    endfunction

    function void check_stop(stop_t got);
      stop_t want;
      n_checked++;
      if (stops_q.size() == 0) begin
        report_err($sformatf("unexpected item city=%0d cost=%0d end=%0b",
                             got.city, got.cost, got.tour_end));
        return;
      end
      want = stops_q.pop_front();
      if (got.city != want.city)
        report_err($sformatf("city %0d, expected %0d", got.city, want.city));
      if (got.cost != want.cost)
        report_err($sformatf("total_cost %0d, expected %0d", got.cost, want.cost));
      if (got.tour_end != want.tour_end)
        report_err($sformatf("tour_end %0b, expected %0b", got.tour_end, want.tour_end));
    endfunction

    function void report_err(string msg);
      n_errors++;
      if (n_errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  tour_board   board;
  bit          calm;
  int unsigned hold_cycles;
  int unsigned n_sent;

  nearest_neighbor_tour_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #300_000_000;
    $display("** nearest_neighbor_tour_unit: FAILED **");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int unsigned gap;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        m_axis_tready <= 0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_stop('{city: m_axis_tdata[4:0], cost: m_axis_tdata[34:5],
                         tour_end: m_axis_tlast});
  end

  // leave tvalid up after an item; the next item or drain() replaces it
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(x, y, last);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.stops_q.size() > 0) @(negedge clk_i);
  endtask

  // random set; coordinates often clustered so ties and coincident points show up
  task automatic send_set(int unsigned n);
    int unsigned span;
    logic [15:0] x, y;
    span = $urandom_range(0, 3);
    for (int unsigned i = 0; i < n; i++) begin
      case (span)
        0: begin x = 16'($urandom_range(0, 3)); y = 16'($urandom_range(0, 3)); end
        1: begin x = 16'($urandom_range(0, 40)); y = 16'($urandom_range(0, 40)); end
        default: begin x = 16'($urandom); y = 16'($urandom); end
      endcase
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    calm = 0;
    hold_cycles = 0;
    n_sent = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // single point
    send_point(16'hFFFF, 16'h0000, 1);
    // all coincident
    send_point(16'h1234, 16'h5678, 0);
    send_point(16'h1234, 16'h5678, 0);
    send_point(16'h1234, 16'h5678, 1);
    // extreme corners, equal-distance tie
    send_point(16'h0000, 16'h0000, 0);
    send_point(16'hFFFF, 16'hFFFF, 0);
    send_point(16'hFFFF, 16'h0000, 0);
    send_point(16'h0000, 16'hFFFF, 0);
    send_point(16'h0000, 16'h0000, 1);
    // hold off the receiver while a full tour builds up
    drain();
    hold_cycles = 3000;
    // overfull set: 32 far points then the dropped ones
    for (int unsigned i = 0; i < NumPoints + 3; i++)
      send_point(i[0] ? 16'hFFFF : 16'h0000, i[1] ? 16'hFFFF : 16'h0000,
                 i == NumPoints + 2);
    drain();

    while (n_sent < 400) begin
      send_set($urandom_range(0, 7) == 0 ? $urandom_range(20, 34)
                                         : $urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) drain();
    end
    calm = 1;
    while (n_sent < 480) send_set($urandom_range(1, 6));

    drain();
    repeat (200) @(negedge clk_i);
    $display("Sent %0d points in %0d tours; checked %0d tour items.",
             n_sent, board.n_tours, board.n_checked);
    if (board.n_errors == 0 && board.stops_q.size() == 0) begin
      $display("** nearest_neighbor_tour_unit: PASSED **");
    end else begin
      $display("** nearest_neighbor_tour_unit: FAILED **");
    end
    $finish;
  end

endmodule
